[design/cpfsk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpfsk_pkg: shared definitions for the 4-tone CPFSK synthesizer
// Item action codes, CSR indexes, register reset values and the quarter-wave
// sine generator used to build the sine ROM at elaboration.
// ----------------------------------------------------------------------------
package cpfsk_pkg;

   // default structural parameters
   localparam int MAX_SYMBOLS_DEF    = 256;
   localparam int PHASE_BITS_DEF     = 32;
   localparam int SINE_ADDR_BITS_DEF = 10;

   // item action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_PULL  = 2'd2;

   // CSR indexes
   localparam int         CSR_IDX_W        = 3;
   localparam logic [2:0] CSR_BASE_STEP    = 3'd0;
   localparam logic [2:0] CSR_SPACING_STEP = 3'd1;
   localparam logic [2:0] CSR_SPS          = 3'd2;
   localparam logic [2:0] CSR_SYMBOL_COUNT = 3'd3;
   localparam logic [2:0] CSR_AMPLITUDE    = 3'd4;
   localparam logic [2:0] CSR_STUFF_ENABLE = 3'd5;

   // CSR reset values
   localparam logic [31:0] RST_BASE_STEP    = 32'd536870912;
   localparam logic [31:0] RST_SPACING_STEP = 32'd524288;
   localparam logic [15:0] RST_SPS          = 16'd8192;
   localparam logic [8:0]  RST_SYMBOL_COUNT = 9'd162;
   localparam logic [7:0]  RST_AMPLITUDE    = 8'd100;
   localparam logic        RST_STUFF_ENABLE = 1'b0;

   // output byte handling
   localparam logic signed [10:0] MIDSCALE   = 11'sd128;
   localparam logic signed [10:0] SAMPLE_MAX = 11'sd255;
   localparam logic [7:0]         STUFF_FROM = 8'h3B;
   localparam logic [7:0]         STUFF_TO   = 8'h3A;
   localparam logic signed [25:0] ROUND_HALF = 26'sd16384;

   // sine generator constants (Q30)
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] ONE_Q30    = 64'd1073741824;
   localparam logic [63:0] HALF_Q30   = 64'd536870912;
   localparam logic [63:0] SINE_PEAK  = 64'd32767;

   // Taylor term n divides by (2n)(2n+1)
   function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
      case (n)
         1:       return term / 64'd6;
         2:       return term / 64'd20;
         3:       return term / 64'd42;
         4:       return term / 64'd72;
         5:       return term / 64'd110;
         6:       return term / 64'd156;
         7:       return term / 64'd210;
         8:       return term / 64'd272;
         9:       return term / 64'd342;
         10:      return term / 64'd420;
         11:      return term / 64'd506;
         12:      return term / 64'd600;
         13:      return term / 64'd702;
         14:      return term / 64'd812;
         15:      return term / 64'd930;
         16:      return term / 64'd1056;
         17:      return term / 64'd1190;
         18:      return term / 64'd1332;
         19:      return term / 64'd1482;
         default: return term;
      endcase
   endfunction

   // round(32767 * sin(2*pi*j / 2^addr_bits)) for the first quarter wave
   function automatic logic [14:0] quarter_sine(input int unsigned j,
                                                input int unsigned addr_bits);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        mag;
      x    = (TWO_PI_Q30 * 64'(j)) >> addr_bits;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n < 20; n++) begin
         if (term != 64'd0) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = taylor_div(term, n);
            if ((n & 1) != 0) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > signed'(ONE_Q30)) begin
         sum = signed'(ONE_Q30);
      end
      mag = ((unsigned'(sum) * SINE_PEAK) + HALF_Q30) >> 30;
      return 15'(mag);
   endfunction

endpackage
`default_nettype wire

[design/cpfsk_tone_synthesizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpfsk_tone_synthesizer: continuous-phase 4-tone FSK audio generator
// Symbol memory, start positioning through an iterative divider, and a
// phase accumulator / sine ROM / multiplier sample path producing 8-bit audio.
//
//  channel | direction | handshake        | payload
//  req     | in        | valid / stall    | action, symbol_index, symbol_value, start_sample
//  rsp     | out       | valid / stall    | sample, last
//  csr     | in        | valid / ready    | index, wdata
//
// Write item: stored while idle, no stall. Pull item: step, phase add, ROM read,
// multiply, output, plus any wait for the output register to drain.
// Start item: total, clamp, then the one-bit-per-cycle divider that
// splits the sample offset (24 steps).
// Reset is synchronous; no clearing pass, symbol memory holds garbage until
// written. A stalled result holds in the output register; new items are
// taken meanwhile until a pull needs that register.
// ----------------------------------------------------------------------------
module cpfsk_tone_synthesizer #(
   parameter int MAX_SYMBOLS    = cpfsk_pkg::MAX_SYMBOLS_DEF,
   parameter int PHASE_BITS     = cpfsk_pkg::PHASE_BITS_DEF,
   parameter int SINE_ADDR_BITS = cpfsk_pkg::SINE_ADDR_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input items
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_action,
   input  wire logic [7:0]                    req_symbol_index,
   input  wire logic [1:0]                    req_symbol_value,
   input  wire logic [23:0]                   req_start_sample,
   // result items
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_sample,
   output logic                               rsp_last,
   // configuration
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cpfsk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_SYMBOLS);
   localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
   localparam int TOT_W   = 16 + CNT_W;
   localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);
   localparam int QA_W    = SINE_ADDR_BITS - 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_CLAMP,
      ST_DIVIDE,
      ST_STEP,
      ST_PHASE,
      ST_ROM,
      ST_MUL,
      ST_OUT
   } state_type;

   // control and configuration
   state_type             state_ff, state_in;
   logic [31:0]           base_ff, base_in;
   logic [31:0]           spacing_ff, spacing_in;
   logic [15:0]           sps_ff, sps_in;
   logic [8:0]            count_ff, count_in;
   logic [7:0]            amp_ff, amp_in;
   logic                  stuff_ff, stuff_in;
   logic                  running_ff, running_in;
   logic [CNT_W-1:0]      cur_symbol_ff, cur_symbol_in;
   logic [15:0]           sym_sample_ff, sym_sample_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_sample_ff, rsp_sample_in;
   logic                  rsp_last_ff, rsp_last_in;

   // datapath
   logic [23:0]           start_ff, start_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [14:0]           sine_mag_ff, sine_mag_in;
   logic                  sine_neg_ff, sine_neg_in;
   logic signed [24:0]    prod_ff, prod_in;
   logic [1:0]            sym_rd_ff;

   logic [1:0]            symbol_store [MAX_SYMBOLS];

   // derived values
   logic [15:0]           sps_eff;
   logic [CNT_W-1:0]      count_eff;
   logic [23:0]           clamped;
   logic                  div_start;
   logic                  div_done;
   logic [23:0]           div_quo;
   logic [15:0]           div_rem;
   logic                  store_we;
   logic [ADDR_W-1:0]     store_waddr;
   logic [ADDR_W-1:0]     store_raddr;
   logic [SINE_ADDR_BITS-1:0] rom_k;
   logic [SINE_ADDR_BITS-2:0] rom_kh;
   logic [SINE_ADDR_BITS-1:0] rom_mirror;
   logic [QA_W-1:0]       rom_addr;
   logic [14:0]           sine_rom [QUARTER+1];
   logic signed [15:0]    sine_val;
   logic signed [25:0]    rounded;
   logic signed [10:0]    level;
   logic signed [10:0]    level_mid;
   logic [7:0]            level_sat;
   logic [16:0]           next_sample;
   logic [CNT_W-1:0]      next_symbol;

   // quarter-wave sine ROM, built at elaboration
   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      localparam logic [14:0] VAL = cpfsk_pkg::quarter_sine(g, SINE_ADDR_BITS);
      assign sine_rom[g] = VAL;
   end

   // effective register values
   always_comb begin
      sps_eff = (sps_ff == 16'd0) ? 16'd1 : sps_ff;
      if (count_ff == 9'd0) begin
         count_eff = CNT_W'(1);
      end else if (32'(count_ff) > MAX_SYMBOLS) begin
         count_eff = CNT_W'(MAX_SYMBOLS);
      end else begin
         count_eff = CNT_W'(count_ff);
      end
   end

   // start offset clamped to message length
   assign clamped = (32'(start_ff) > 32'(total_ff)) ? 24'(total_ff) : start_ff;

   cpfsk_div #(
      .NUM_W(24),
      .DEN_W(16)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clamped),
      .divisor  (sps_eff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // symbol memory ports
   assign store_we    = (state_ff == ST_IDLE) && req_valid
                        && (req_action == cpfsk_pkg::ACT_WRITE)
                        && (32'(req_symbol_index) < MAX_SYMBOLS);
   assign store_waddr = ADDR_W'(req_symbol_index);
   assign store_raddr = cur_symbol_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (store_we) begin
         symbol_store[store_waddr] <= req_symbol_value;
      end
      sym_rd_ff <= symbol_store[store_raddr];
   end

   // sine ROM address folding: mirror in each half, negate the second half
   always_comb begin
      rom_k      = phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS];
      rom_kh     = rom_k[SINE_ADDR_BITS-2:0];
      rom_mirror = SINE_ADDR_BITS'(2 ** (SINE_ADDR_BITS - 1)) - {1'b0, rom_kh};
      if ({1'b0, rom_kh} <= SINE_ADDR_BITS'(QUARTER)) begin
         rom_addr = QA_W'(rom_kh);
      end else begin
         rom_addr = QA_W'(rom_mirror);
      end
   end

   // sample rounding, midscale offset, saturation, stuffing
   always_comb begin
      sine_val  = sine_neg_ff ? -$signed({1'b0, sine_mag_ff}) : $signed({1'b0, sine_mag_ff});
      rounded   = 26'(prod_ff) + cpfsk_pkg::ROUND_HALF;
      level     = 11'(rounded >>> 15);
      level_mid = level + cpfsk_pkg::MIDSCALE;
      if (level_mid < 11'sd0) begin
         level_sat = 8'd0;
      end else if (level_mid > cpfsk_pkg::SAMPLE_MAX) begin
         level_sat = 8'hFF;
      end else begin
         level_sat = level_mid[7:0];
      end
      if (stuff_ff && (level_sat == cpfsk_pkg::STUFF_FROM)) begin
         level_sat = cpfsk_pkg::STUFF_TO;
      end
      next_sample = 17'(sym_sample_ff) + 17'd1;
      next_symbol = cur_symbol_ff + CNT_W'(1);
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      spacing_in    = spacing_ff;
      sps_in        = sps_ff;
      count_in      = count_ff;
      amp_in        = amp_ff;
      stuff_in      = stuff_ff;
      running_in    = running_ff;
      cur_symbol_in = cur_symbol_ff;
      sym_sample_in = sym_sample_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      step_in       = step_ff;
      sine_mag_in   = sine_mag_ff;
      sine_neg_in   = sine_neg_ff;
      prod_in       = prod_ff;
      div_start     = 1'b0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            cpfsk_pkg::CSR_BASE_STEP:    base_in    = csr_wdata;
            cpfsk_pkg::CSR_SPACING_STEP: spacing_in = csr_wdata;
            cpfsk_pkg::CSR_SPS:          sps_in     = csr_wdata[15:0];
            cpfsk_pkg::CSR_SYMBOL_COUNT: count_in   = csr_wdata[8:0];
            cpfsk_pkg::CSR_AMPLITUDE:    amp_in     = csr_wdata[7:0];
            cpfsk_pkg::CSR_STUFF_ENABLE: stuff_in   = csr_wdata[0];
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  cpfsk_pkg::ACT_START: begin
                     start_in = req_start_sample;
                     state_in = ST_TOTAL;
                  end
                  cpfsk_pkg::ACT_PULL: begin
                     if (running_ff && (cur_symbol_ff < count_eff)) begin
                        state_in = ST_STEP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TOTAL: begin
            total_in = TOT_W'(sps_eff) * TOT_W'(count_eff);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               cur_symbol_in = CNT_W'(div_quo);
               sym_sample_in = div_rem;
               phase_in      = '0;
               running_in    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_STEP: begin
            step_in  = PHASE_BITS'(34'(base_ff) + 34'(spacing_ff) * 34'(sym_rd_ff));
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            phase_in = phase_ff + step_ff;
            state_in = ST_ROM;
         end
         ST_ROM: begin
            sine_mag_in = sine_rom[rom_addr];
            sine_neg_in = rom_k[SINE_ADDR_BITS-1];
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, amp_ff}) * sine_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = level_sat;
               if (next_sample >= 17'(sps_eff)) begin
                  sym_sample_in = 16'd0;
                  cur_symbol_in = next_symbol;
                  rsp_last_in   = (next_symbol >= count_eff);
               end else begin
                  sym_sample_in = next_sample[15:0];
                  rsp_last_in   = (cur_symbol_ff >= count_eff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, configuration and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= cpfsk_pkg::RST_BASE_STEP;
         spacing_ff    <= cpfsk_pkg::RST_SPACING_STEP;
         sps_ff        <= cpfsk_pkg::RST_SPS;
         count_ff      <= cpfsk_pkg::RST_SYMBOL_COUNT;
         amp_ff        <= cpfsk_pkg::RST_AMPLITUDE;
         stuff_ff      <= cpfsk_pkg::RST_STUFF_ENABLE;
         running_ff    <= 1'b0;
         cur_symbol_ff <= '0;
         sym_sample_ff <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_sample_ff <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         spacing_ff    <= spacing_in;
         sps_ff        <= sps_in;
         count_ff      <= count_in;
         amp_ff        <= amp_in;
         stuff_ff      <= stuff_in;
         running_ff    <= running_in;
         cur_symbol_ff <= cur_symbol_in;
         sym_sample_ff <= sym_sample_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      total_ff    <= total_in;
      step_ff     <= step_in;
      sine_mag_ff <= sine_mag_in;
      sine_neg_ff <= sine_neg_in;
      prod_ff     <= prod_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

[design/cpfsk_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpfsk_div: iterative restoring divider
// One quotient bit per cycle; quotient and remainder valid when done pulses.
// ----------------------------------------------------------------------------
module cpfsk_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient,
   output logic [DEN_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   // trial subtract of one bit step
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = ~diff[DEN_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

[design/cpfsk_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpfsk_checker: port-level checks for the CPFSK synthesizer
// Watches the item channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cpfsk_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_sample,
   input wire logic       rsp_last
);

   // a stalled result item holds
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result item changed while stalled");

   // an accepted start item holds off the input
   property p_start_busy;
      @(posedge clock) disable iff (reset)
         req_valid && !req_stall && (req_action == cpfsk_pkg::ACT_START) |=> req_stall;
   endproperty
   a_start_busy: assert property (p_start_busy)
      else $error("start item did not hold off the input");

   // reset leaves the block idle with no pending result
   property p_reset_idle;
      @(posedge clock) reset |=> !rsp_valid && !req_stall;
   endproperty
   a_reset_idle: assert property (p_reset_idle)
      else $error("block not idle after reset");

endmodule

bind cpfsk_tone_synthesizer cpfsk_checker u_cpfsk_checker (.*);
`default_nettype wire

[tb/sv/tb_cpfsk_tone_synthesizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_cpfsk_tone_synthesizer: self-checking bench for the 4-tone CPFSK synthesizer
// Preloads the symbol memory, then walks a directed table (idle, extremes,
// clamping, stuffing, end of message) and runs random configuration phases
// with start / pull / write traffic. Each accepted item is run through an
// in-bench sample predictor and every result is compared in order, with
// random input gaps, random result stalls and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_cpfsk_tone_synthesizer;
   import cpfsk_pkg::*;

   localparam int          SINE_N        = 1 << SINE_ADDR_BITS_DEF;
   localparam int          MEM_DEPTH     = MAX_SYMBOLS_DEF;
   localparam int          SETTLE_CYCLES = 64;
   localparam int          LONG_HOLD     = 300;
   localparam int          RANDOM_ITEMS  = 450;
   localparam logic [1:0]  ACT_IGNORED   = 2'd3;
   localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;

   typedef struct packed {
      logic [7:0] sample;
      logic       last;
   } sample_t;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  index;
      logic [1:0]  value;
      logic [23:0] start;
   } item_t;

   typedef enum logic       {ROW_CSR, ROW_ITEM} row_kind_e;
   typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_mode_e;

   // one directed step: a register write or an item; data is csr data or start
   typedef struct packed {
      row_kind_e   kind;
      logic [2:0]  reg_idx;
      logic [31:0] data;
      logic [1:0]  action;
      logic [7:0]  index;
      logic [1:0]  value;
      exp_mode_e   mode;
      sample_t     given;
   } dir_row_t;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action       = ACT_WRITE;
   logic [7:0]  req_symbol_index = 8'd0;
   logic [1:0]  req_symbol_value = 2'd0;
   logic [23:0] req_start_sample = 24'd0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_sample;
   logic        rsp_last;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE_STEP;
   logic [31:0] csr_wdata        = 32'd0;

   cpfsk_tone_synthesizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_symbol_index (req_symbol_index),
      .req_symbol_value (req_symbol_value),
      .req_start_sample (req_start_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state and register shadow
   int          sine_rom [SINE_N];
   logic [1:0]  tone_mem [MEM_DEPTH];
   logic [8:0]  sym_pos;
   logic [15:0] pos_in_sym;
   logic [31:0] nco_phase;
   logic        gen_on;
   logic [31:0] cfg_base, cfg_spacing;
   logic [15:0] cfg_sps;
   logic [8:0]  cfg_count;
   logic [7:0]  cfg_amp;
   logic        cfg_stuff;

   sample_t     pending_samples [$];
   int          fail_count      = 0;
   int          samples_checked = 0;
   int          ends_seen       = 0;
   int          busy_items      = 0;
   int          phases          = 0;
   bit          sender_idling   = 1'b1;
   bit          rsp_idling      = 1'b1;
   bit          quiet           = 1'b0;
   bit          hold_request    = 1'b0;

   // round(32767 * sin(2*pi*j/N)) over the first quarter, Q30 Taylor series
   function automatic int sine_q15(input int unsigned j);
      longint unsigned x, term;
      longint          acc;
      x    = (TWO_PI_Q30 * 64'(j)) / 64'(SINE_N);
      term = x;
      acc  = longint'(x);
      for (int n = 1; n < 20 && term != 64'd0; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      return int'((64'(acc) * 64'd32767 + 64'd536870912) >> 30);
   endfunction

   function automatic int eff_sps();
      return (cfg_sps == 16'd0) ? 1 : int'(cfg_sps);
   endfunction

   function automatic int eff_count();
      if (cfg_count == 9'd0) return 1;
      return (cfg_count > 9'(MEM_DEPTH)) ? MEM_DEPTH : int'(cfg_count);
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         CSR_BASE_STEP:    cfg_base    = data;
         CSR_SPACING_STEP: cfg_spacing = data;
         CSR_SPS:          cfg_sps     = data[15:0];
         CSR_SYMBOL_COUNT: cfg_count   = data[8:0];
         CSR_AMPLITUDE:    cfg_amp     = data[7:0];
         CSR_STUFF_ENABLE: cfg_stuff   = data[0];
         default: ;
      endcase
   endfunction

   // advance the generator by one item; produced says whether a sample results
   function automatic void predict_sample(input item_t it, output bit produced,
                                          output sample_t r);
      int      sps, cnt, s, total, level;
      int      addr;
      longint  acc;
      sps      = eff_sps();
      cnt      = eff_count();
      produced = 1'b0;
      r        = '0;
      case (it.action)
         ACT_WRITE: tone_mem[it.index] = it.value;
         ACT_START: begin
            total = sps * cnt;
            s     = int'(it.start);
            if (s > total) s = total;
            sym_pos    = 9'(s / sps);
            pos_in_sym = 16'(s % sps);
            nco_phase  = 32'd0;
            gen_on     = 1'b1;
         end
         ACT_PULL: begin
            if (gen_on && int'(sym_pos) < cnt) begin
               nco_phase = nco_phase + cfg_base + 32'(tone_mem[sym_pos[7:0]]) * cfg_spacing;
               addr  = int'(nco_phase[31:32-SINE_ADDR_BITS_DEF]);
               // floor((amp*sin + half) / 2^15) rounds half up
               acc   = longint'(cfg_amp) * longint'(sine_rom[addr]) + 64'sd16384;
               level = int'(acc >>> 15) + 128;
               if (level < 0) level = 0;
               if (level > 255) level = 255;
               if (cfg_stuff && level == int'(STUFF_FROM)) level = int'(STUFF_TO);
               pos_in_sym = pos_in_sym + 16'd1;
               if (int'(pos_in_sym) >= sps) begin
                  pos_in_sym = 16'd0;
                  sym_pos    = sym_pos + 9'd1;
               end
               r.sample = 8'(level);
               r.last   = (int'(sym_pos) >= cnt);
               produced = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // offer one item, hold it until accepted, then queue what it produces
   task automatic send_item(input item_t it, input exp_mode_e mode, input sample_t given);
      bit      produced;
      sample_t r;
      req_valid        <= 1'b1;
      req_action       <= it.action;
      req_symbol_index <= it.index;
      req_symbol_value <= it.value;
      req_start_sample <= it.start;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_sample(it, produced, r);
      if (mode == EXP_GIVEN) begin
         pending_samples.push_back(given);
      end else if (mode == EXP_MODEL && produced) begin
         pending_samples.push_back(r);
      end
      if (it.action != ACT_IGNORED && (it.action != ACT_PULL || produced)) busy_items++;
   endtask

   task automatic send_op(input logic [1:0] action, input logic [7:0] index,
                          input logic [1:0] value, input logic [23:0] start);
      send_item('{action, index, value, start}, EXP_MODEL, '0);
   endtask

   // random sender gap between items
   task automatic maybe_pause();
      if (sender_idling && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_all_samples();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   // idle the block before touching registers
   task automatic settle_idle();
      wait_all_samples();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // keep holds valid high for a following write in the next cycle
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data, input bit keep);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      apply_register(idx, data);
      if (!keep) csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [31:0] base, input logic [31:0] spacing,
                                input logic [15:0] sps, input logic [8:0] count,
                                input logic [7:0] amp, input logic stuff);
      settle_idle();
      csr_write(CSR_BASE_STEP, base, 1'b1);
      csr_write(CSR_SPACING_STEP, spacing, 1'b1);
      csr_write(CSR_SPS, 32'(sps), 1'b1);
      csr_write(CSR_SYMBOL_COUNT, 32'(count), 1'b1);
      csr_write(CSR_AMPLITUDE, 32'(amp), 1'b1);
      csr_write(CSR_STUFF_ENABLE, 32'(stuff), 1'b0);
      phases++;
   endtask

   // start offset: mostly inside the message, some near its end, some anywhere
   function automatic logic [23:0] pick_offset();
      int total;
      total = eff_sps() * eff_count();
      case ($urandom_range(0, 9))
         0, 1:    return 24'($urandom);
         2, 3, 4: return 24'(total - int'($urandom_range(0, (total < 12) ? total : 12)));
         default: return 24'($urandom_range(0, total));
      endcase
   endfunction

   function automatic dir_row_t reg_row(input logic [2:0] idx, input logic [31:0] data);
      return '{ROW_CSR, idx, data, ACT_WRITE, 8'd0, 2'd0, EXP_NONE, '0};
   endfunction

   function automatic dir_row_t op_row(input logic [1:0] action, input logic [31:0] start,
                                       input exp_mode_e mode, input logic [7:0] sample,
                                       input logic last);
      return '{ROW_ITEM, CSR_BASE_STEP, start, action, 8'd0, 2'd0, mode, '{sample, last}};
   endfunction

   function automatic dir_row_t wr_row(input logic [7:0] index, input logic [1:0] value);
      return '{ROW_ITEM, CSR_BASE_STEP, 32'd0, ACT_WRITE, index, value, EXP_NONE, '0};
   endfunction

   // result side: check accepted samples, drive random stall bursts
   initial begin : sample_checker
      int      burst_left;
      int      hold_left;
      sample_t want;
      burst_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_samples.size() == 0) begin
               $error("unexpected result: sample %0d last %0d", rsp_sample, rsp_last);
               fail_count++;
            end else begin
               want = pending_samples.pop_front();
               samples_checked++;
               if (want.last) ends_seen++;
               if (rsp_sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_stall   <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idling && !quiet && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      dir_row_t dir_rows [$];
      int       n_ops;
      int       target;
      int       j;
      logic [31:0] base, spacing;
      logic [15:0] sps;
      logic [8:0]  count;
      logic [7:0]  amp;

      // sine table, mirrored quarter wave
      for (int k = 0; k < SINE_N / 2; k++) begin
         j = (k <= SINE_N / 4) ? k : SINE_N / 2 - k;
         sine_rom[k]              = sine_q15(j);
         sine_rom[k + SINE_N / 2] = -sine_rom[k];
      end
      cfg_base    = RST_BASE_STEP;
      cfg_spacing = RST_SPACING_STEP;
      cfg_sps     = RST_SPS;
      cfg_count   = RST_SYMBOL_COUNT;
      cfg_amp     = RST_AMPLITUDE;
      cfg_stuff   = RST_STUFF_ENABLE;
      sym_pos     = '0;
      pos_in_sym  = '0;
      nco_phase   = '0;
      gen_on      = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill every symbol entry so no pull reads an unwritten one
      for (int k = 0; k < MEM_DEPTH; k++) begin
         send_op(ACT_WRITE, 8'(k), 2'($urandom), 24'($urandom));
         maybe_pause();
      end

      // directed: quarter-turn steps land on sine peaks and zeros
      dir_rows = '{
         reg_row(CSR_SPS, 32'd2),
         reg_row(CSR_SYMBOL_COUNT, 32'd2),
         reg_row(CSR_BASE_STEP, QUARTER_TURN),
         reg_row(CSR_SPACING_STEP, 32'd0),
         reg_row(CSR_AMPLITUDE, 32'd255),
         reg_row(CSR_STUFF_ENABLE, 32'd0),
         op_row(ACT_PULL, 32'd0, EXP_NONE, 8'd0, 1'b0),        // idle, before any start
         wr_row(8'd255, 2'd3),
         wr_row(8'd0, 2'd0),
         op_row(ACT_START, 32'd0, EXP_NONE, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd255, 1'b0),     // saturates high
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd128, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd0, 1'b0),       // saturates low
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd128, 1'b1),
         op_row(ACT_PULL, 32'd0, EXP_NONE, 8'd0, 1'b0),        // finished
         op_row(ACT_START, 32'hFF_FFFF, EXP_NONE, 8'd0, 1'b0), // clamps to end
         op_row(ACT_PULL, 32'd0, EXP_NONE, 8'd0, 1'b0),
         op_row(ACT_START, 32'd3, EXP_NONE, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd255, 1'b1),
         op_row(ACT_IGNORED, 32'd0, EXP_NONE, 8'd0, 1'b0),
         reg_row(CSR_AMPLITUDE, 32'd69),
         reg_row(CSR_STUFF_ENABLE, 32'd1),
         op_row(ACT_START, 32'd0, EXP_NONE, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd197, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd128, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, STUFF_TO, 1'b0),   // 0x3B stuffed
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd128, 1'b1),
         reg_row(CSR_SPS, 32'd0),
         reg_row(CSR_SYMBOL_COUNT, 32'd0),
         reg_row(CSR_AMPLITUDE, 32'd0),
         op_row(ACT_START, 32'd0, EXP_NONE, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_GIVEN, 8'd128, 1'b1),     // one-sample message
         op_row(ACT_PULL, 32'd0, EXP_NONE, 8'd0, 1'b0),
         reg_row(CSR_SYMBOL_COUNT, 32'd300),                   // clamps to memory depth
         reg_row(CSR_SPS, 32'd1),
         reg_row(CSR_SPACING_STEP, 32'hFFFF_FFFF),
         reg_row(CSR_BASE_STEP, 32'd0),
         reg_row(CSR_AMPLITUDE, 32'd255),
         op_row(ACT_START, 32'd254, EXP_NONE, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_MODEL, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_MODEL, 8'd0, 1'b0),
         op_row(ACT_PULL, 32'd0, EXP_NONE, 8'd0, 1'b0)
      };
      for (int r = 0; r < dir_rows.size(); r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            if (r == 0 || dir_rows[r-1].kind != ROW_CSR) settle_idle();
            csr_write(dir_rows[r].reg_idx, dir_rows[r].data,
                      r + 1 < dir_rows.size() && dir_rows[r+1].kind == ROW_CSR);
         end else begin
            send_item('{dir_rows[r].action, dir_rows[r].index, dir_rows[r].value,
                        dir_rows[r].data[23:0]}, dir_rows[r].mode, dir_rows[r].given);
            maybe_pause();
         end
      end

      // back-pressure: receiver holds off while pulls keep coming
      load_settings(32'($urandom), RST_SPACING_STEP, 16'd3, 9'd40, 8'd200, 1'b1);
      send_op(ACT_START, 8'd0, 2'd0, 24'd0);
      hold_request = 1'b1;
      repeat (40) send_op(ACT_PULL, 8'd0, 2'd0, 24'd0);
      wait_all_samples();
      repeat (20) begin
         send_op(ACT_PULL, 8'd0, 2'd0, 24'd0);
         maybe_pause();
      end

      // random phases, each with a fresh register setting
      target = busy_items + RANDOM_ITEMS;
      while (busy_items < target) begin
         if (busy_items >= target - 60) quiet = 1'b1;
         sender_idling = ($urandom_range(0, 2) != 0);
         rsp_idling    = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 5))
            0:       base = 32'd0;
            1:       base = 32'hFFFF_FFFF;
            default: base = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0:       spacing = 32'd0;
            1:       spacing = 32'hFFFF_FFFF;
            2:       spacing = $urandom;
            default: spacing = 32'($urandom_range(0, 32'h003F_FFFF));
         endcase
         case ($urandom_range(0, 9))
            0:       sps = 16'd0;
            1:       sps = 16'd1;
            2:       sps = 16'hFFFF;
            3:       sps = 16'($urandom);
            default: sps = 16'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       count = 9'd0;
            1:       count = 9'd1;
            2:       count = 9'd256;
            3:       count = 9'($urandom_range(257, 511));
            default: count = 9'($urandom_range(1, 20));
         endcase
         case ($urandom_range(0, 4))
            0:       amp = 8'd0;
            1:       amp = 8'd255;
            default: amp = 8'($urandom);
         endcase
         load_settings(base, spacing, sps, count, amp, 1'($urandom));

         send_op(ACT_START, 8'd0, 2'd0, pick_offset());
         n_ops = $urandom_range(20, 50);
         repeat (n_ops) begin
            case ($urandom_range(0, 19))
               0, 1:    send_op(ACT_WRITE, 8'($urandom), 2'($urandom), 24'($urandom));
               2, 3:    send_op(ACT_START, 8'($urandom), 2'($urandom), pick_offset());
               4:       send_op(ACT_IGNORED, 8'($urandom), 2'($urandom), 24'($urandom));
               default: send_op(ACT_PULL, 8'($urandom), 2'($urandom), 24'($urandom));
            endcase
            maybe_pause();
         end
      end

      settle_idle();
      $display("Checked %0d samples (%0d end-of-message) over %0d items",
               samples_checked, ends_seen, busy_items);
      $display("and %0d register settings, with stalls on both channels", phases);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
design/cpfsk_pkg.sv
design/cpfsk_div.sv
design/cpfsk_tone_synthesizer.sv
design/cpfsk_checker.sv
tb/sv/tb_cpfsk_tone_synthesizer.sv
